FILE: sv/fan_curve_temperature_controller_core_defines.svh
// Assertion macros shared by the fan curve checker.
`ifndef FAN_CURVE_TEMPERATURE_CONTROLLER_CORE_DEFINES_SVH
`define FAN_CURVE_TEMPERATURE_CONTROLLER_CORE_DEFINES_SVH

// Check a property while reset is low.
`define FCTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FCTC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/fctc_pkg.sv
package fctc_pkg;

   // Field and internal widths
   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int COUNT_W  = 4;
   localparam int TEMP_W   = 8;
   localparam int DRIVE_W  = 8;
   localparam int ENTRY_W  = 5;

   // Defaults for the top-level parameters
   localparam int DEF_SAMPLES_PER_READING = 10;
   localparam int DEF_CURVE_ENTRIES       = 17;

   // Degrees = (10000*sum - 18787360*N) / (70732*N), truncated toward zero
   localparam int SUM_SCALE  = 10000;
   localparam int DEG_OFFSET = 18787360;
   localparam int DEG_SCALE  = 70732;

   // Reciprocal divide: magnitude below 128 divisors, quotient below 128
   localparam int MAG_W       = 28;
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 48;
   localparam int QUOT_W      = 7;
   localparam int PROD_W      = MAG_W + RECIP_W;

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 8'sd127;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -8'sd128;

   // One point of the fan curve, drives already inverted: 255 - pct*255/100
   typedef struct packed {
      logic signed [TEMP_W-1:0] thresh;
      logic [DRIVE_W-1:0]       drive_a;
      logic [DRIVE_W-1:0]       drive_b;
   } curve_point_type;

   localparam int CURVE_LEN = 17;

   localparam curve_point_type CURVE_TABLE [CURVE_LEN] = '{
      '{8'sd34,  8'd243, 8'd245},   // 5%   4%
      '{8'sd35,  8'd235, 8'd245},   // 8%   4%
      '{8'sd36,  8'd230, 8'd245},   // 10%  4%
      '{8'sd37,  8'd225, 8'd245},   // 12%  4%
      '{8'sd39,  8'd220, 8'd245},   // 14%  4%
      '{8'sd40,  8'd215, 8'd243},   // 16%  5%
      '{8'sd42,  8'd204, 8'd240},   // 20%  6%
      '{8'sd44,  8'd192, 8'd238},   // 25%  7%
      '{8'sd46,  8'd179, 8'd233},   // 30%  9%
      '{8'sd48,  8'd166, 8'd217},   // 35%  15%
      '{8'sd50,  8'd141, 8'd192},   // 45%  25%
      '{8'sd51,  8'd115, 8'd164},   // 55%  36%
      '{8'sd52,  8'd90,  8'd133},   // 65%  48%
      '{8'sd53,  8'd51,  8'd97},    // 80%  62%
      '{8'sd54,  8'd26,  8'd67},    // 90%  74%
      '{8'sd55,  8'd13,  8'd36},    // 95%  86%
      '{8'sd125, 8'd0,   8'd0}      // 100% 100%
   };

endpackage

FILE: sv/fan_curve_temperature_controller_core.sv
// Fan curve controller: sums raw 12-bit sensor samples and, on every
// SAMPLES_PER_READING-th sample, emits one word with the averaged temperature
// in whole degrees (saturated to -128..127), the two inverted PWM compare
// values of the first curve point whose threshold is at or above it, the
// point's index and a match flag; with no match the previous drives are
// repeated and matched is 0. Other samples produce no word. One sample is
// taken every cycle while req_stall is low. The closing sum of a reading is
// registered, then offset and magnitude, reciprocal multiply and curve
// lookup are each registered in turn; the 28x32 reciprocal multiply stage
// sets the clock. Three internal stages plus the output register buffer
// results, so samples keep flowing while a result waits.
module fan_curve_temperature_controller_core
   import fctc_pkg::*;
#(
   parameter int SAMPLES_PER_READING = DEF_SAMPLES_PER_READING,
   parameter int CURVE_ENTRIES       = DEF_CURVE_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_W-1:0]        req_adc_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [TEMP_W-1:0]   rsp_temperature,
   output logic [DRIVE_W-1:0]         rsp_fan0_drive,
   output logic [DRIVE_W-1:0]         rsp_fan1_drive,
   output logic [ENTRY_W-1:0]         rsp_entry_chosen,
   output logic                       rsp_matched
);

   localparam logic [COUNT_W-1:0] READ_COUNT = COUNT_W'(SAMPLES_PER_READING);
   localparam logic [63:0] DIVISOR     = 64'(DEG_SCALE) * 64'(SAMPLES_PER_READING);
   localparam logic [63:0] OFFSET64    = 64'(DEG_OFFSET) * 64'(SAMPLES_PER_READING);
   localparam logic [31:0] OFFSET      = OFFSET64[31:0];
   localparam logic [63:0] SAT_LIMIT64 = DIVISOR * 64'd128;
   localparam logic [31:0] SAT_LIMIT   = SAT_LIMIT64[31:0];
   localparam logic [63:0] RECIP64     =
      ((64'd1 << RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

   // Accumulator
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_next;
   logic [COUNT_W-1:0] count_next;
   logic               reading_done;
   logic               req_accept;

   // Stage 1: completed sum
   logic               p1_valid_ff, p1_valid_in;
   logic [SUM_W-1:0]   p1_sum_ff;
   logic               p1_free;

   // Stage 2: sign, saturation and magnitude of the scaled numerator
   logic               p2_valid_ff, p2_valid_in;
   logic               p2_neg_ff, p2_sat_ff;
   logic [MAG_W-1:0]   p2_mag_ff;
   logic               p2_free;
   logic [31:0]        scaled;
   logic [31:0]        diff;
   logic               num_neg;

   // Stage 3: temperature
   logic                      p3_valid_ff, p3_valid_in;
   logic signed [TEMP_W-1:0]  p3_temp_ff, p3_temp_in;
   logic                      p3_free;
   logic [PROD_W-1:0]         prod;
   logic [QUOT_W-1:0]         quot;

   // Output register and held drives
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0]  rsp_temp_ff;
   logic [DRIVE_W-1:0]        rsp_drive_a_ff, rsp_drive_b_ff;
   logic [ENTRY_W-1:0]        rsp_entry_ff;
   logic                      rsp_matched_ff;
   logic [DRIVE_W-1:0]        held_a_ff, held_b_ff;
   logic                      out_free;
   logic                      hit;
   logic [ENTRY_W-1:0]        chosen;
   logic [DRIVE_W-1:0]        drive_a, drive_b;

   // Flow control: a stage loads when it is empty or its word moves on
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign p3_free    = !p3_valid_ff || out_free;
   assign p2_free    = !p2_valid_ff || p3_free;
   assign p1_free    = !p1_valid_ff || p2_free;
   assign req_stall  = !p1_free;
   assign req_accept = req_valid && !req_stall;

   // Accumulate samples, restart after a full reading
   always_comb begin
      sum_next     = sum_ff + SUM_W'(req_adc_sample);
      count_next   = count_ff + COUNT_W'(1);
      reading_done = (count_next == READ_COUNT);
      sum_in       = sum_ff;
      count_in     = count_ff;
      if (req_accept) begin
         sum_in   = reading_done ? '0 : sum_next;
         count_in = reading_done ? '0 : count_next;
      end
   end

   assign p1_valid_in = p1_free ? (req_accept && reading_done) : p1_valid_ff;

   // Scale the sum and remove the offset, keep sign and magnitude
   always_comb begin
      scaled  = 32'(p1_sum_ff) * 32'(SUM_SCALE);
      num_neg = (scaled < OFFSET);
      diff    = num_neg ? (OFFSET - scaled) : (scaled - OFFSET);
   end

   assign p2_valid_in = p2_free ? p1_valid_ff : p2_valid_ff;

   // Divide by the constant divisor through its reciprocal, then saturate
   always_comb begin
      prod = PROD_W'(p2_mag_ff) * PROD_W'(RECIP);
      quot = prod[RECIP_SHIFT +: QUOT_W];
      priority if (p2_sat_ff) begin
         p3_temp_in = p2_neg_ff ? TEMP_MIN : TEMP_MAX;
      end else if (p2_neg_ff) begin
         p3_temp_in = TEMP_W'(0) - {1'b0, quot};
      end else begin
         p3_temp_in = {1'b0, quot};
      end
   end

   assign p3_valid_in = p3_free ? p2_valid_ff : p3_valid_ff;

   // Find the first curve point at or above the temperature
   always_comb begin
      hit    = 1'b0;
      chosen = '0;
      for (int i = CURVE_LEN - 1; i >= 0; i--) begin
         if ((i < CURVE_ENTRIES) &&
             ($signed(p3_temp_ff) <= $signed(CURVE_TABLE[i].thresh))) begin
            hit    = 1'b1;
            chosen = ENTRY_W'(i);
         end
      end
      drive_a = hit ? CURVE_TABLE[chosen].drive_a : held_a_ff;
      drive_b = hit ? CURVE_TABLE[chosen].drive_b : held_b_ff;
   end

   assign rsp_valid_in = out_free ? p3_valid_ff : rsp_valid_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_a_ff    <= CURVE_TABLE[0].drive_a;
         held_b_ff    <= CURVE_TABLE[0].drive_b;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         p3_valid_ff  <= p3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (p3_valid_ff && out_free && hit) begin
            held_a_ff <= drive_a;
            held_b_ff <= drive_b;
         end
      end
   end

   // Payload stages, loaded whenever the stage is free
   always_ff @(posedge clock) begin
      if (p1_free) begin
         p1_sum_ff <= sum_next;
      end
      if (p2_free) begin
         p2_neg_ff <= num_neg;
         p2_sat_ff <= (diff >= SAT_LIMIT);
         p2_mag_ff <= diff[MAG_W-1:0];
      end
      if (p3_free) begin
         p3_temp_ff <= p3_temp_in;
      end
      if (out_free) begin
         rsp_temp_ff    <= p3_temp_ff;
         rsp_drive_a_ff <= drive_a;
         rsp_drive_b_ff <= drive_b;
         rsp_entry_ff   <= chosen;
         rsp_matched_ff <= hit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temperature  = rsp_temp_ff;
   assign rsp_fan0_drive   = rsp_drive_a_ff;
   assign rsp_fan1_drive   = rsp_drive_b_ff;
   assign rsp_entry_chosen = rsp_entry_ff;
   assign rsp_matched      = rsp_matched_ff;

endmodule

FILE: sv/fctc_checker.sv
`include "fan_curve_temperature_controller_core_defines.svh"

module fctc_checker
   import fctc_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [SAMPLE_W-1:0]        req_adc_sample,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [TEMP_W-1:0]   rsp_temperature,
   input logic [DRIVE_W-1:0]         rsp_fan0_drive,
   input logic [DRIVE_W-1:0]         rsp_fan1_drive,
   input logic [ENTRY_W-1:0]         rsp_entry_chosen,
   input logic                       rsp_matched
);

   // A stalled result word holds
   `FCTC_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temperature) &&
      $stable(rsp_fan0_drive) && $stable(rsp_fan1_drive) &&
      $stable(rsp_entry_chosen) && $stable(rsp_matched),
      "result word changed while stalled")

   // No result word right after reset
   `FCTC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // A miss always reports entry zero
   `FCTC_ASSERT(a_miss_entry, clock, reset,
      rsp_valid && !rsp_matched |-> rsp_entry_chosen == '0, "miss with nonzero entry")

   // Nothing matches above the hottest curve point
   `FCTC_ASSERT(a_hit_range, clock, reset,
      rsp_valid && rsp_matched |->
      $signed(rsp_temperature) <= $signed(CURVE_TABLE[CURVE_LEN-1].thresh),
      "match above top threshold")

endmodule

bind fan_curve_temperature_controller_core fctc_checker u_fctc_checker (.*);
